/* rtl/qslerp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and CORDIC constants for the quaternion slerp block.
package qslerp_pkg;

  localparam int FRAC_BITS = 15;
  localparam int WORK_BITS = 30;
  localparam int CW        = 34;   // CORDIC datapath width
  localparam int MAX_STEPS = 30;

  localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;

  // atan(2^-i) in Q4.30, truncated
  localparam logic signed [CW-1:0] ATAN_TAB [MAX_STEPS] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
    34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
    34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
    34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
    34'sd31, 34'sd15, 34'sd7, 34'sd3, 34'sd1
  };

  typedef struct packed {
    logic signed [15:0] from_w;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_w;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
    logic        [15:0] fraction;
  } req_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               used_linear;
    logic               flipped_target;
  } res_t;

endpackage

/* rtl/qslerp_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module qslerp_sqrt import qslerp_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [30:0]       root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = 32;

  logic              v   [STEPS+1];
  logic [63:0]       rem [STEPS+1];
  logic [63:0]       acc [STEPS+1];
  logic [SIDE_W-1:0] sd  [STEPS+1];

  assign v[0]   = in_valid;
  assign rem[0] = rad;
  assign acc[0] = 64'd0;
  assign sd[0]  = in_side;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = acc[k] + BITV;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      sd[k+1] <= sd[k];
      if (rem[k] >= trial) begin
        rem[k+1] <= rem[k] - trial;
        acc[k+1] <= (acc[k] >> 1) + BITV;
      end else begin
        rem[k+1] <= rem[k];
        acc[k+1] <= acc[k] >> 1;
      end
    end
  end

  assign out_valid = v[STEPS];
  assign root      = acc[STEPS][30:0];
  assign out_side  = sd[STEPS];

endmodule

/* rtl/qslerp_atan.sv */
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC giving atan2(y, x), one iteration per stage.
module qslerp_atan import qslerp_pkg::*; #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] z_out,
  output logic [SIDE_W-1:0]    out_side
);

  logic                 v  [STEPS+1];
  logic signed [CW-1:0] x  [STEPS+1];
  logic signed [CW-1:0] y  [STEPS+1];
  logic signed [CW-1:0] z  [STEPS+1];
  logic [SIDE_W-1:0]    sd [STEPS+1];

  assign v[0]  = in_valid;
  assign x[0]  = x_in;
  assign y[0]  = y_in;
  assign z[0]  = '0;
  assign sd[0] = in_side;

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [CW-1:0] ANG = ATAN_TAB[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      sd[i+1] <= sd[i];
      if (y[i] > 0) begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ANG;
      end else begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ANG;
      end
    end
  end

  assign out_valid = v[STEPS];
  assign z_out     = z[STEPS];
  assign out_side  = sd[STEPS];

endmodule

/* rtl/qslerp_sin.sv */
`timescale 1ns / 1ps
// Two-lane pipelined rotation CORDIC giving the sine of each angle.
module qslerp_sin import qslerp_pkg::*; #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] za_in,
  input  logic signed [CW-1:0] zb_in,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] ya_out,
  output logic signed [CW-1:0] yb_out,
  output logic [SIDE_W-1:0]    out_side
);

  logic                 v  [STEPS+1];
  logic [SIDE_W-1:0]    sd [STEPS+1];
  logic signed [CW-1:0] x  [2][STEPS+1];
  logic signed [CW-1:0] y  [2][STEPS+1];
  logic signed [CW-1:0] z  [2][STEPS+1];

  assign v[0]  = in_valid;
  assign sd[0] = in_side;
  assign z[0][0] = za_in;
  assign z[1][0] = zb_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      sd[i+1] <= sd[i];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign x[l][0] = GAIN_INV;
    assign y[l][0] = '0;

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
      localparam logic signed [CW-1:0] ANG = ATAN_TAB[i];

      always_ff @(posedge clk) begin
        if (z[l][i] >= 0) begin
          x[l][i+1] <= x[l][i] - (y[l][i] >>> i);
          y[l][i+1] <= y[l][i] + (x[l][i] >>> i);
          z[l][i+1] <= z[l][i] - ANG;
        end else begin
          x[l][i+1] <= x[l][i] + (y[l][i] >>> i);
          y[l][i+1] <= y[l][i] - (x[l][i] >>> i);
          z[l][i+1] <= z[l][i] + ANG;
        end
      end
    end
  end

  assign out_valid = v[STEPS];
  assign ya_out    = y[0][STEPS];
  assign yb_out    = y[1][STEPS];
  assign out_side  = sd[STEPS];

endmodule

/* rtl/qslerp_div.sv */
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider: weight = sine * 2^30 / den, clamped to +-2.0.
module qslerp_div import qslerp_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] na_in,
  input  logic signed [CW-1:0] nb_in,
  input  logic [30:0]          den_in,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic signed [32:0]   wa_out,
  output logic signed [32:0]   wb_out,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int QB = 33;   // quotient bits computed
  localparam logic [QB-1:0] WMAX = QB'(64'd1 << (WORK_BITS + 1));

  logic              v   [QB+1];
  logic [SIDE_W-1:0] sd  [QB+1];
  logic [30:0]       den [QB+1];
  logic [63:0]       rem [2][QB+1];
  logic [QB-1:0]     quo [2][QB+1];
  logic              neg [2][QB+1];
  logic              ovf [2][QB+1];
  logic signed [CW-1:0] num [2];
  logic signed [32:0]   w   [2];

  assign num[0] = na_in;
  assign num[1] = nb_in;

  // prep stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sd[0]  <= in_side;
    den[0] <= den_in;
  end

  for (genvar k = 0; k < QB; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      sd[k+1]  <= sd[k];
      den[k+1] <= den[k];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [CW-1:0] mag;
    assign mag = num[l][CW-1] ? CW'(-num[l]) : CW'(num[l]);

    always_ff @(posedge clk) begin
      neg[l][0] <= num[l][CW-1];
      rem[l][0] <= {mag, {WORK_BITS{1'b0}}};
      quo[l][0] <= '0;
      ovf[l][0] <= mag >= {den_in, 3'b000};
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
      logic [63:0] dsh;
      assign dsh = {33'd0, den[k]} << (QB - 1 - k);

      always_ff @(posedge clk) begin
        neg[l][k+1] <= neg[l][k];
        ovf[l][k+1] <= ovf[l][k];
        if (rem[l][k] >= dsh) begin
          rem[l][k+1] <= rem[l][k] - dsh;
          quo[l][k+1] <= {quo[l][k][QB-2:0], 1'b1};
        end else begin
          rem[l][k+1] <= rem[l][k];
          quo[l][k+1] <= {quo[l][k][QB-2:0], 1'b0};
        end
      end
    end

    logic [QB-1:0] qc;
    assign qc   = (ovf[l][QB] || quo[l][QB] > WMAX) ? WMAX : quo[l][QB];
    assign w[l] = neg[l][QB] ? -$signed(qc) : $signed(qc);
  end

  assign out_valid = v[QB];
  assign out_side  = sd[QB];
  assign wa_out    = w[0];
  assign wb_out    = w[1];

endmodule

/* rtl/quaternion_slerp.sv */
`timescale 1ns / 1ps
// Top level of the fixed-point quaternion slerp pipeline.
//
// Fully pipelined quaternion slerp. A request is taken on any cycle in which
// start is high (busy is always low), so one quaternion pair per clock is
// sustained. Each result appears on result with done high for exactly one
// cycle. Between request and result lie five front stages (capture,
// products, dot sum and flip, c squared, radicand), a 32-stage square root,
// a zero-sine stage, the atan2 CORDIC, two angle stages, the two-lane sine
// CORDIC, a 34-stage divider and three blend stages. Results leave in
// request order and cannot be held off, so the consumer must take every one.
// lerp_threshold sits at byte address 0 of the APB port; write it only while
// no request is in flight.
module quaternion_slerp import qslerp_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  // result channel
  output logic        done,
  output res_t        result,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic        REG_THR   = 1'b0;   // word index of lerp_threshold
  localparam logic [15:0] THR_RESET = 16'd32765;
  localparam logic [15:0] FRAC_ONE  = 16'd1 << FRAC_BITS;
  localparam logic [30:0] WORK_ONE  = 31'd1 << WORK_BITS;

  // data that rides alongside the arithmetic units
  typedef struct packed {
    req_t        q;
    logic        flip;
    logic        lin;
    logic [30:0] c;
    logic [30:0] dq;
    logic [30:0] sn;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [15:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_THR) begin
      thr <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THR) ? {16'd0, thr} : 32'd0;
  assign busy   = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: capture request
  // ---------------------------------------------------------------------------
  logic v1;
  req_t q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    q1 <= req;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: four component products
  // ---------------------------------------------------------------------------
  logic               v2;
  req_t               q2;
  logic signed [31:0] p2 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    q2    <= q1;
    p2[0] <= q1.from_w * q1.to_w;
    p2[1] <= q1.from_x * q1.to_x;
    p2[2] <= q1.from_y * q1.to_y;
    p2[3] <= q1.from_z * q1.to_z;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot sum, shortest-arc flip, saturate cosine, fraction, linear test
  // ---------------------------------------------------------------------------
  logic signed [33:0] dot;
  logic [33:0]        dmag;
  logic [30:0]        c_sat;
  logic [15:0]        frac_cl;
  logic [30:0]        dq_now;
  logic               v3;
  side_t              s3;

  assign dot     = 34'(p2[0]) + 34'(p2[1]) + 34'(p2[2]) + 34'(p2[3]);
  assign dmag    = dot[33] ? 34'(-dot) : 34'(dot);
  assign c_sat   = (dmag > 34'(WORK_ONE)) ? WORK_ONE : dmag[30:0];
  assign frac_cl = (q2.fraction > FRAC_ONE) ? FRAC_ONE : q2.fraction;
  assign dq_now  = {frac_cl, {(WORK_BITS - FRAC_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s3.q    <= q2;
    s3.flip <= dot[33];
    s3.c    <= c_sat;
    s3.dq   <= dq_now;
    s3.lin  <= c_sat > {thr, {(WORK_BITS - FRAC_BITS){1'b0}}};
    s3.sn   <= '0;
  end

  // ---------------------------------------------------------------------------
  // Stages 4-5: c squared, then radicand 1 - c^2
  // ---------------------------------------------------------------------------
  logic        v4, v5;
  side_t       s4, s5;
  logic [61:0] csq4;
  logic [63:0] rad5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s4   <= s3;
    csq4 <= s3.c * s3.c;
    s5   <= s4;
    rad5 <= (64'd1 << (2 * WORK_BITS)) - {2'b00, csq4};
  end

  // ---------------------------------------------------------------------------
  // Sine of omega: pipelined square root
  // ---------------------------------------------------------------------------
  logic        vq;
  logic [30:0] root;
  logic [SIDE_W-1:0] sq_side;
  side_t       sq;

  qslerp_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .rad      (rad5),
    .in_side  (s5),
    .out_valid(vq),
    .root     (root),
    .out_side (sq_side)
  );

  assign sq = side_t'(sq_side);

  // Stage 6: zero sine forces the linear weights
  logic  v6;
  side_t s6, s6_next;

  always_comb begin
    s6_next     = sq;
    s6_next.sn  = root;
    s6_next.lin = sq.lin || root == 31'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= vq;
    end
  end

  always_ff @(posedge clk) begin
    s6 <= s6_next;
  end

  // ---------------------------------------------------------------------------
  // omega = atan2(sine, cosine)
  // ---------------------------------------------------------------------------
  logic                 v7;
  logic signed [CW-1:0] omega;
  logic [SIDE_W-1:0]    at_side;

  qslerp_atan #(.STEPS(CORDIC_STEPS), .SIDE_W(SIDE_W)) u_atan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v6),
    .x_in     ($signed({3'b000, s6.c})),
    .y_in     ($signed({3'b000, s6.sn})),
    .in_side  (s6),
    .out_valid(v7),
    .z_out    (omega),
    .out_side (at_side)
  );

  // Stage 8: clamp omega at zero
  logic        v8;
  side_t       s8;
  logic [31:0] ang8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    s8   <= side_t'(at_side);
    ang8 <= omega[CW-1] ? 32'd0 : omega[31:0];
  end

  // Stage 9: scaled angles (1-d)*omega and d*omega
  logic                 v9;
  side_t                s9;
  logic [62:0]          pa_ang, pb_ang;
  logic signed [CW-1:0] za9, zb9;

  assign pa_ang = (WORK_ONE - s8.dq) * ang8;
  assign pb_ang = s8.dq * ang8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    s9  <= s8;
    za9 <= $signed({1'b0, pa_ang[62:WORK_BITS]});
    zb9 <= $signed({1'b0, pb_ang[62:WORK_BITS]});
  end

  // ---------------------------------------------------------------------------
  // Sines of the two scaled angles, then division by sine of omega
  // ---------------------------------------------------------------------------
  logic                 v10;
  logic signed [CW-1:0] ya, yb;
  logic [SIDE_W-1:0]    sn_side;
  side_t                s10;

  qslerp_sin #(.STEPS(CORDIC_STEPS), .SIDE_W(SIDE_W)) u_sin (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v9),
    .za_in    (za9),
    .zb_in    (zb9),
    .in_side  (s9),
    .out_valid(v10),
    .ya_out   (ya),
    .yb_out   (yb),
    .out_side (sn_side)
  );

  assign s10 = side_t'(sn_side);

  logic               v11;
  logic signed [32:0] wa_sph, wb_sph;
  logic [SIDE_W-1:0]  dv_side;
  side_t              s11;

  qslerp_div #(.SIDE_W(SIDE_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v10),
    .na_in    (ya),
    .nb_in    (yb),
    .den_in   (s10.sn),
    .in_side  (s10),
    .out_valid(v11),
    .wa_out   (wa_sph),
    .wb_out   (wb_sph),
    .out_side (dv_side)
  );

  assign s11 = side_t'(dv_side);

  // ---------------------------------------------------------------------------
  // Stage 12: pick weights, negate target on flip
  // ---------------------------------------------------------------------------
  logic               v12, lin12, flip12;
  logic signed [32:0] wa12, wb12;
  logic signed [15:0] a12 [4];
  logic signed [16:0] b12 [4];
  logic signed [15:0] tgt [4];

  assign tgt[0] = s11.q.to_w;
  assign tgt[1] = s11.q.to_x;
  assign tgt[2] = s11.q.to_y;
  assign tgt[3] = s11.q.to_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    lin12  <= s11.lin;
    flip12 <= s11.flip;
    if (s11.lin) begin
      wa12 <= $signed({2'b00, WORK_ONE - s11.dq});
      wb12 <= $signed({2'b00, s11.dq});
    end else begin
      wa12 <= wa_sph;
      wb12 <= wb_sph;
    end
    a12[0] <= s11.q.from_w;
    a12[1] <= s11.q.from_x;
    a12[2] <= s11.q.from_y;
    a12[3] <= s11.q.from_z;
    for (int k = 0; k < 4; k++) begin
      b12[k] <= s11.flip ? -17'(tgt[k]) : 17'(tgt[k]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 13: weighted products
  // ---------------------------------------------------------------------------
  logic               v13, lin13, flip13;
  logic signed [48:0] pa13 [4];
  logic signed [49:0] pb13 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else begin
      v13 <= v12;
    end
  end

  always_ff @(posedge clk) begin
    lin13  <= lin12;
    flip13 <= flip12;
    for (int k = 0; k < 4; k++) begin
      pa13[k] <= a12[k] * wa12;
      pb13[k] <= b12[k] * wb12;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 14: round half up, saturate, present result for one cycle
  // ---------------------------------------------------------------------------
  localparam logic signed [50:0] HALF   = 51'sd1 <<< (WORK_BITS - 1);
  localparam logic signed [20:0] SATHI  = 21'sd32767;
  localparam logic signed [20:0] SATLO  = -21'sd32768;

  logic signed [50:0] acc  [4];
  logic signed [20:0] shv  [4];
  logic signed [15:0] comp [4];

  for (genvar k = 0; k < 4; k++) begin : g_blend
    assign acc[k]  = 51'(pa13[k]) + 51'(pb13[k]) + HALF;
    assign shv[k]  = acc[k][50:WORK_BITS];
    assign comp[k] = (shv[k] > SATHI) ? 16'sh7fff :
                     (shv[k] < SATLO) ? 16'sh8000 : shv[k][15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v13;
    end
  end

  always_ff @(posedge clk) begin
    result.out_w          <= comp[0];
    result.out_x          <= comp[1];
    result.out_y          <= comp[2];
    result.out_z          <= comp[3];
    result.used_linear    <= lin13;
    result.flipped_target <= flip13;
  end

endmodule
